FILE: hw/rtl/plt_pkg.sv
// Shared types, constants and helper functions for the piecewise-linear tone map.
`default_nettype none
package plt_pkg;

  // Number of curve segments; the thresholds of the segment search follow from it.
  localparam int Segments = 6;

  localparam int PixW    = 8;   // sample width
  localparam int SegW    = 3;   // segment index width
  localparam int CoefW   = 32;  // one signed Q16.16 coefficient
  localparam int RegW    = 2 * CoefW;
  localparam int FracW   = 16;  // fraction bits of Q16.16
  localparam int NumRegs = Segments + 1;
  localparam int IdxW    = $clog2(NumRegs);
  localparam int ProdW   = CoefW + PixW + 1;  // coefficient times a non-negative sample
  localparam int AccW    = ProdW + 1;         // product plus offset
  localparam int ScaleW  = PixW + $clog2(Segments + 1) + 1;

  localparam logic [IdxW-1:0] SatReg = IdxW'(Segments);

  // Results strictly above 254.0 in the saturation stage force full scale.
  localparam logic signed [AccW-1:0] SatHigh = AccW'(254 * (1 << FracW));

  typedef struct packed {
    logic signed [CoefW-1:0] gain;
    logic signed [CoefW-1:0] offset;
  } coef_t;

  typedef coef_t [NumRegs-1:0] coef_bank_t;

  localparam coef_t CoefReset = '{gain: CoefW'(1 << FracW), offset: '0};

  // Smallest k with x*Segments <= 255*(k+1); the last segment catches the rest.
  function automatic logic [SegW-1:0] pick_segment(input logic [PixW-1:0] x);
    logic [SegW-1:0]   k;
    logic              found;
    logic [ScaleW-1:0] xs;
    k     = SegW'(Segments - 1);
    found = 1'b0;
    xs    = ScaleW'(x) * ScaleW'(Segments);
    for (int i = 0; i < Segments - 1; i++) begin
      if (!found && xs <= ScaleW'(255 * (i + 1))) begin
        k     = SegW'(i);
        found = 1'b1;
      end
    end
    return k;
  endfunction

  // Floor of a Q16.16 value, clamped to the sample range.
  function automatic logic [PixW-1:0] floor_clamp(input logic signed [AccW-1:0] v);
    logic [PixW-1:0] r;
    if (v[AccW-1]) begin
      r = '0;
    end else if (|v[AccW-2:FracW+PixW]) begin
      r = '1;
    end else begin
      r = v[FracW+PixW-1:FracW];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/plt_stream_if.sv
// Valid/ready stream interfaces for the sample input and the mapped sample output.
`default_nettype none
interface plt_in_if;
  import plt_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface plt_out_if;
  import plt_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic [SegW-1:0] segment;

  modport source (output valid, output pixel_out, output segment, input ready);
  modport sink   (input valid, input pixel_out, input segment, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/plt_coef_regs.sv
// Coefficient register file: segment and saturation gain/offset pairs.
`default_nettype none
module plt_coef_regs (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [plt_pkg::IdxW-1:0] cfg_index,
  input  wire logic [plt_pkg::RegW-1:0] cfg_data,
  output plt_pkg::coef_bank_t         coefs
);
  import plt_pkg::*;

  coef_bank_t bank;

  // Writes to an index past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        bank[i] <= CoefReset;
      end
    end else if (cfg_we && cfg_index < IdxW'(NumRegs)) begin
      bank[cfg_index] <= coef_t'(cfg_data);
    end
  end

  assign coefs = bank;

endmodule
`default_nettype wire

FILE: hw/rtl/piecewise_linear_tone_map.sv
// Top level of the piecewise-linear tone map with its five-stage datapath.
// A sample accepted into stage 1 moves through stages 2, 3 and 4 and is on the outputs
// once it reaches stage 5, where its transaction can complete.
// Throughput: one sample per cycle; each stage holds only while the stage after it is full.
// The pipeline limit is the two 32x9 multipliers, each followed by its own register.
// Reset (rst, synchronous) empties every stage and loads all coefficient pairs
// with gain 1.0 and offset 0.0, so the block maps each sample to itself.
`default_nettype none
module piecewise_linear_tone_map (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [plt_pkg::IdxW-1:0] cfg_index,
  input  wire logic [plt_pkg::RegW-1:0] cfg_data,
  plt_in_if.sink                        pix_in,
  plt_out_if.source                     pix_out
);
  import plt_pkg::*;

  // Coefficients only change while the pipeline is empty: the user is bound to this, the block
  // itself does not enforce it, and every stage reads the live register file.
  coef_bank_t coefs;

  plt_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // Stage 1 holds the sample and its segment, stage 2 the curve product, stage 3
  // the clamped curve value, stage 4 the saturation product and stage 5 the result.
  logic                    s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;
  logic                    s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
  logic [PixW-1:0]         s1_x;
  logic [SegW-1:0]         s1_seg, s2_seg, s3_seg, s4_seg, s5_seg;
  logic signed [ProdW-1:0] s2_prod, s4_prod;
  logic [PixW-1:0]         s3_p1, s5_pix;

  logic signed [ProdW-1:0] s2_prod_next, s4_prod_next;
  logic signed [AccW-1:0]  v1, v2;
  logic [PixW-1:0]         s3_p1_next, s5_pix_next;
  coef_t                   seg_coef, sat_coef;

  // A stage can take a new transaction when it is empty or its content moves on
  // in the same cycle; bubbles are therefore squeezed out during a stall.
  assign s5_rdy = !s5_vld || pix_out.ready;
  assign s4_rdy = !s4_vld || s5_rdy;
  assign s3_rdy = !s3_vld || s4_rdy;
  assign s2_rdy = !s2_vld || s3_rdy;
  assign s1_rdy = !s1_vld || s2_rdy;

  assign pix_in.ready = s1_rdy;

  // Curve stage: select the segment pair, multiply, then add the offset and clamp.
  assign seg_coef     = coefs[s1_seg];
  assign s2_prod_next = ProdW'(seg_coef.gain) * ProdW'($signed({1'b0, s1_x}));
  assign v1           = AccW'(s2_prod) + AccW'(coefs[s2_seg].offset);
  assign s3_p1_next   = floor_clamp(v1);

  // Saturation stage: same shape, but anything above 254.0 gives full scale.
  assign sat_coef     = coefs[SatReg];
  assign s4_prod_next = ProdW'(sat_coef.gain) * ProdW'($signed({1'b0, s3_p1}));
  assign v2           = AccW'(s4_prod) + AccW'(sat_coef.offset);
  assign s5_pix_next  = (v2 > SatHigh) ? '1 : floor_clamp(v2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld <= pix_in.valid;
      if (s2_rdy) s2_vld <= s1_vld;
      if (s3_rdy) s3_vld <= s2_vld;
      if (s4_rdy) s4_vld <= s3_vld;
      if (s5_rdy) s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_x   <= pix_in.pixel_in;
      s1_seg <= pick_segment(pix_in.pixel_in);
    end
    if (s2_rdy) begin
      s2_prod <= s2_prod_next;
      s2_seg  <= s1_seg;
    end
    if (s3_rdy) begin
      s3_p1  <= s3_p1_next;
      s3_seg <= s2_seg;
    end
    if (s4_rdy) begin
      s4_prod <= s4_prod_next;
      s4_seg  <= s3_seg;
    end
    if (s5_rdy) begin
      s5_pix <= s5_pix_next;
      s5_seg <= s4_seg;
    end
  end

  assign pix_out.valid     = s5_vld;
  assign pix_out.pixel_out = s5_pix;
  assign pix_out.segment   = s5_seg;

  // An accepted transaction always lands in the first stage.
  a_intake: assert property (@(posedge clk) disable iff (rst)
    pix_in.valid && pix_in.ready |=> s1_vld)
    else $error("accepted sample did not enter stage 1");

  // A full saturation-product stage that cannot move keeps its contents.
  a_s4_hold: assert property (@(posedge clk) disable iff (rst)
    s4_vld && !s5_rdy |=> s4_vld && $stable(s4_prod) && $stable(s4_seg))
    else $error("stage 4 lost or changed a stalled transaction");

  // The reported segment is always one of the curve segments.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.segment <= SegW'(Segments - 1))
    else $error("segment index out of range");

endmodule
`default_nettype wire
